// ===== rtl/timestamp_range_search_core_assert.svh =====
// Assertion macros shared by the checker of the timestamp range search core.
// Each macro samples on the rising clock edge and is disabled while in reset.
`ifndef TIMESTAMP_RANGE_SEARCH_CORE_ASSERT_SVH
`define TIMESTAMP_RANGE_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication
`define TSRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tsrs assertion failed");

// Next-cycle implication
`define TSRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tsrs assertion failed");

`endif

// ===== rtl/tsrs_pkg.sv =====
// ----------------------------------------------------------------------------
// tsrs_pkg
// Shared constants, codes and types of the timestamp range search core.
// ----------------------------------------------------------------------------
package tsrs_pkg;

  // Store geometry
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int TS_W   = 32;
  localparam int IDX_W  = 10;

  // Stream widths
  localparam int IN_TDATA_W  = 3 * TS_W;
  localparam int OP_W        = 2;
  localparam int ST_W        = 3;
  localparam int OUT_TDATA_W = ((2 * IDX_W + 7) / 8) * 8;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_APPENDED = 3'd0,
    ST_FULL     = 3'd1,
    ST_FOUND    = 3'd2,
    ST_NONE     = 3'd3,
    ST_CLEARED  = 3'd4
  } status_e;

  // One result beat
  typedef struct packed {
    status_e              status;
    logic [IDX_W-1:0]     first_index;
    logic [IDX_W-1:0]     last_index;
  } res_t;

  // Search step request and answer
  typedef struct packed {
    logic             cmp_en;
    logic             inclusive;
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
    logic [CNT_W-1:0] mid;
    logic [TS_W-1:0]  key;
  } step_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
    logic [CNT_W-1:0] mid;
    logic             more;
  } step_rsp_t;

endpackage

// ===== rtl/tsrs_ram.sv =====
// ----------------------------------------------------------------------------
// tsrs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tsrs_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/tsrs_step.sv =====
// ----------------------------------------------------------------------------
// tsrs_step
// Shared compare-and-step unit: narrows one binary search interval per probe
// and forms the next probe index.
// ----------------------------------------------------------------------------
module tsrs_step
  import tsrs_pkg::*;
(
  input  step_req_t         req_i,
  input  logic [TS_W-1:0]   rdata_i,
  output step_rsp_t         rsp_o
);

  logic             go_right;
  logic [CNT_W-1:0] lo_n;
  logic [CNT_W-1:0] hi_n;

  // Compare probed timestamp against key
  assign go_right = req_i.inclusive ? (rdata_i <= req_i.key) : (rdata_i < req_i.key);

  // Narrow the interval only when a probe result is present
  always_comb begin
    lo_n = req_i.lo;
    hi_n = req_i.hi;
    if (req_i.cmp_en) begin
      if (go_right) begin
        lo_n = req_i.mid + CNT_W'(1);
      end else begin
        hi_n = req_i.mid;
      end
    end
  end

  // Next probe index
  assign rsp_o.lo   = lo_n;
  assign rsp_o.hi   = hi_n;
  assign rsp_o.mid  = lo_n + ((hi_n - lo_n) >> 1);
  assign rsp_o.more = (lo_n < hi_n);

endmodule

// ===== rtl/tsrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsrs_ctrl
// Sequencer: takes one operation, updates the record count, drives the store
// and runs both binary searches through the shared step unit.
// ----------------------------------------------------------------------------
module tsrs_ctrl
  import tsrs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [TS_W-1:0]   record_time_i,
  input  logic [TS_W-1:0]   query_start_i,
  input  logic [TS_W-1:0]   query_end_i,
  output logic              we_o,
  output logic [ADDR_W-1:0] waddr_o,
  output logic [TS_W-1:0]   wdata_o,
  output logic [ADDR_W-1:0] raddr_o,
  input  logic [TS_W-1:0]   rdata_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_START  = 4'b0010,
    S_SEARCH = 4'b0100,
    S_RESP   = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] lo_q, lo_d;
  logic [CNT_W-1:0] hi_q, hi_d;
  logic [CNT_W-1:0] mid_q, mid_d;
  logic [CNT_W-1:0] lb_q, lb_d;
  logic             pass_q, pass_d;
  logic [TS_W-1:0]  start_q, start_d;
  logic [TS_W-1:0]  end_q, end_d;
  res_t             res_q, res_d;
  step_req_t        step_req;
  step_rsp_t        step_rsp;
  logic [CNT_W-1:0] ub;
  logic             found;

  // Shared step unit
  assign step_req.cmp_en    = (state_q == S_SEARCH);
  assign step_req.inclusive = pass_q;
  assign step_req.lo        = lo_q;
  assign step_req.hi        = hi_q;
  assign step_req.mid       = mid_q;
  assign step_req.key       = pass_q ? end_q : start_q;

  tsrs_step u_step (
    .req_i   (step_req),
    .rdata_i (rdata_i),
    .rsp_o   (step_rsp)
  );

  // Range check on the finished pair of searches
  assign ub    = step_rsp.lo;
  assign found = (lb_q < count_q) && (ub != '0) && (lb_q <= ub - CNT_W'(1));

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = res_q;
  assign waddr_o     = count_q[ADDR_W-1:0];
  assign wdata_o     = record_time_i;
  assign raddr_o     = step_rsp.mid[ADDR_W-1:0];

  // Sequencer
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    lo_d    = step_rsp.lo;
    hi_d    = step_rsp.hi;
    mid_d   = step_rsp.mid;
    lb_d    = lb_q;
    pass_d  = pass_q;
    start_d = start_q;
    end_d   = end_q;
    res_d   = res_q;
    we_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d   = '{status: ST_NONE, first_index: '0, last_index: '0};
          state_d = S_RESP;
          case (op_e'(op_i))
            OP_APPEND: begin
              if (count_q == CNT_W'(DEPTH)) begin
                res_d.status = ST_FULL;
              end else begin
                we_o         = 1'b1;
                count_d      = count_q + CNT_W'(1);
                res_d.status = ST_APPENDED;
              end
            end
            OP_CLEAR: begin
              count_d      = '0;
              res_d.status = ST_CLEARED;
            end
            OP_QUERY: begin
              start_d = query_start_i;
              end_d   = query_end_i;
              lo_d    = '0;
              hi_d    = count_q;
              pass_d  = 1'b0;
              state_d = S_START;
            end
            default: begin
              res_d.status = ST_NONE;
            end
          endcase
        end
      end
      S_START, S_SEARCH: begin
        if (step_rsp.more) begin
          state_d = S_SEARCH;
        end else if (!pass_q) begin
          // Lower bound done; start the upper bound
          lb_d    = step_rsp.lo;
          lo_d    = '0;
          hi_d    = count_q;
          pass_d  = 1'b1;
          state_d = S_START;
        end else begin
          if (found) begin
            res_d = '{status: ST_FOUND,
                      first_index: IDX_W'(lb_q),
                      last_index: IDX_W'(ub - CNT_W'(1))};
          end else begin
            res_d = '{status: ST_NONE, first_index: '0, last_index: '0};
          end
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pass_q  <= pass_d;
    end
  end

  // Search and result payload
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    lb_q    <= lb_d;
    start_q <= start_d;
    end_q   <= end_d;
    res_q   <= res_d;
  end

endmodule

// ===== rtl/timestamp_range_search_core.sv =====
// ----------------------------------------------------------------------------
// timestamp_range_search_core
// Store of ascending record timestamps with append, clear and range query.
// ----------------------------------------------------------------------------
// One operation is taken at a time. Append, clear and the unused code pass
// from the accepted beat through the sequencer's result register into the
// output register. A range query runs a lower-bound search for query_start
// and then an upper-bound search for query_end over the records held; each
// search passes through a setup state and then probes in the search state,
// at most ceil(log2(count+1)) probes. Search speed is set by the single
// read port of the timestamp memory, whose registered data feeds the shared
// compare-and-step unit once per cycle. The output register lets the next
// beat be taken while a result waits. first_index and last_index are record
// indices and read zero unless status is "range found".
module timestamp_range_search_core
  import tsrs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] record_time, [63:32] query_start, [95:64] query_end
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] operation
  input  logic [OP_W-1:0]        s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [9:0] first_index, [19:10] last_index, upper bits zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [2:0] status
  output logic [ST_W-1:0]        m_axis_tuser
);

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [TS_W-1:0]   wdata;
  logic [ADDR_W-1:0] raddr;
  logic [TS_W-1:0]   rdata;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              out_valid_q, out_valid_d;
  res_t              out_q;

  // Sequencer
  tsrs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .op_i          (s_axis_tuser),
    .record_time_i (s_axis_tdata[TS_W-1:0]),
    .query_start_i (s_axis_tdata[2*TS_W-1:TS_W]),
    .query_end_i   (s_axis_tdata[3*TS_W-1:2*TS_W]),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .raddr_o       (raddr),
    .rdata_i       (rdata),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // Timestamp store
  tsrs_ram #(
    .Width (TS_W),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = OUT_TDATA_W'({out_q.last_index, out_q.first_index});

endmodule

// ===== rtl/tsrs_checker.sv =====
// ----------------------------------------------------------------------------
// tsrs_checker
// Port-level checks of the timestamp range search core, bound to the top.
// ----------------------------------------------------------------------------
`include "timestamp_range_search_core_assert.svh"

module tsrs_checker
  import tsrs_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [OP_W-1:0]        s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [ST_W-1:0]        m_axis_tuser
);

  // Hold a stalled result beat
  `TSRS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // One operation at a time: busy right after a beat is taken
  `TSRS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // Indices read zero unless a range was found
  `TSRS_ASSERT_NOW(a_idx_zero, m_axis_tvalid && (m_axis_tuser != ST_FOUND),
    m_axis_tdata == '0)

  // A found range is ordered
  `TSRS_ASSERT_NOW(a_range_order, m_axis_tvalid && (m_axis_tuser == ST_FOUND),
    m_axis_tdata[IDX_W-1:0] <= m_axis_tdata[2*IDX_W-1:IDX_W])

  // Status is a defined code
  `TSRS_ASSERT_NOW(a_status_code, m_axis_tvalid, m_axis_tuser <= ST_CLEARED)

endmodule

bind timestamp_range_search_core tsrs_checker u_tsrs_checker (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the timestamp range search core: drives append,
// clear, query and unused-code beats into the slave stream, predicts every
// result beat with a local copy of the record store, and compares each
// master-side beat against the oldest prediction under random back-pressure.
// ----------------------------------------------------------------------------
module testbench
  import tsrs_pkg::*;
;

  // Unused operation code, answered as "no valid range"
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Run-length guard, far above the slowest legal run
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned RANDOM_ITEMS  = 450;
  localparam logic [TS_W-1:0] TS_MAX    = '1;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [31:0] record_time, [63:32] query_start, [95:64] query_end
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  // [1:0] operation
  logic [OP_W-1:0]        s_axis_tuser  = OP_APPEND;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [9:0] first_index, [19:10] last_index, upper bits zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // [2:0] status
  logic [ST_W-1:0]        m_axis_tuser;

  // Local copy of the record store
  logic [TS_W-1:0]        shadow_stamps [DEPTH];
  logic [CNT_W-1:0]       shadow_count = '0;

  res_t                   pending_results [$];
  int unsigned            mismatch_count = 0;
  int unsigned            cycle_count    = 0;
  int unsigned            burst_left     = 0;
  int unsigned            stall_mode     = 0;
  int unsigned            stall_phase    = 0;

  timestamp_range_search_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Free-running clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Count held records below key (strictly below, or at or below if inclusive)
  function automatic int unsigned records_below(logic [TS_W-1:0] key, bit inclusive);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    bit          go_right;
    lo = 0;
    hi = 32'(shadow_count);
    while (lo < hi) begin
      mid      = lo + (hi - lo) / 2;
      go_right = inclusive ? (shadow_stamps[ADDR_W'(mid)] <= key)
                           : (shadow_stamps[ADDR_W'(mid)] < key);
      if (go_right) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    return lo;
  endfunction

  // Apply one operation to the local store and return the result it causes
  function automatic res_t search_outcome(logic [OP_W-1:0] op, logic [TS_W-1:0] rec,
                                          logic [TS_W-1:0] qs, logic [TS_W-1:0] qe);
    res_t        r;
    int unsigned lb;
    int unsigned ub;
    r.status      = ST_NONE;
    r.first_index = '0;
    r.last_index  = '0;
    case (op)
      OP_APPEND: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_stamps[shadow_count[ADDR_W-1:0]] = rec;
          shadow_count = shadow_count + CNT_W'(1);
          r.status     = ST_APPENDED;
        end
      end
      OP_CLEAR: begin
        shadow_count = '0;
        r.status     = ST_CLEARED;
      end
      OP_QUERY: begin
        lb = records_below(qs, 1'b0);
        ub = records_below(qe, 1'b1);
        if (lb < shadow_count && ub > 0 && lb <= ub - 1) begin
          r.status      = ST_FOUND;
          r.first_index = IDX_W'(lb);
          r.last_index  = IDX_W'(ub - 1);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Drive one beat in bursts with random gaps; record its result on acceptance
  task automatic send_beat(logic [OP_W-1:0] op, logic [TS_W-1:0] rec,
                           logic [TS_W-1:0] qs, logic [TS_W-1:0] qe);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {qe, qs, rec};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(search_outcome(op, rec, qs, qe));
    burst_left--;
  endtask

  // Hold the source idle until every predicted beat has come back
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Query bound near a held record, at an extreme, or fully random
  function automatic logic [TS_W-1:0] pick_bound();
    int unsigned     sel;
    logic [TS_W-1:0] base;
    sel = $urandom_range(0, 9);
    if (shadow_count == 0 || sel == 0) begin
      return $urandom();
    end
    if (sel == 1) begin
      return ($urandom_range(0, 1) == 0) ? '0 : TS_MAX;
    end
    base = shadow_stamps[ADDR_W'($urandom_range(0, shadow_count - 1))];
    case ($urandom_range(0, 2))
      0:       return base;
      1:       return base + $urandom_range(1, 3);
      default: return base - $urandom_range(1, 3);
    endcase
  endfunction

  // Empty store, extreme timestamps, every miss case and the unused code
  task automatic test_edge_cases();
    send_beat(OP_QUERY,  $urandom(), '0, TS_MAX);
    send_beat(OP_UNUSED, $urandom(), $urandom(), $urandom());
    send_beat(OP_CLEAR,  $urandom(), $urandom(), $urandom());
    send_beat(OP_APPEND, '0,         $urandom(), $urandom());
    send_beat(OP_APPEND, '0,         $urandom(), $urandom());
    send_beat(OP_APPEND, 32'd5,      $urandom(), $urandom());
    send_beat(OP_APPEND, 32'd100,    $urandom(), $urandom());
    send_beat(OP_APPEND, TS_MAX,     $urandom(), $urandom());
    send_beat(OP_APPEND, TS_MAX,     $urandom(), $urandom());
    send_beat(OP_QUERY,  $urandom(), '0,         TS_MAX);
    send_beat(OP_QUERY,  $urandom(), 32'd1,      32'd99);
    // first record after start lies beyond the last one before end
    send_beat(OP_QUERY,  $urandom(), 32'd6,      32'd99);
    send_beat(OP_QUERY,  $urandom(), TS_MAX,     TS_MAX);
    send_beat(OP_QUERY,  $urandom(), '0,         '0);
    send_beat(OP_QUERY,  $urandom(), 32'd100,    32'd5);
    send_beat(OP_QUERY,  $urandom(), 32'd101,    TS_MAX - 1);
    send_beat(OP_UNUSED, TS_MAX,     TS_MAX,     TS_MAX);
    send_beat(OP_CLEAR,  TS_MAX,     TS_MAX,     TS_MAX);
    send_beat(OP_APPEND, 32'd10,     $urandom(), $urandom());
    send_beat(OP_APPEND, 32'd20,     $urandom(), $urandom());
    // nothing at or after start, then nothing at or before end
    send_beat(OP_QUERY,  $urandom(), 32'd30,     TS_MAX);
    send_beat(OP_QUERY,  $urandom(), '0,         32'd5);
    send_beat(OP_QUERY,  $urandom(), 32'd10,     32'd20);
    send_beat(OP_CLEAR,  $urandom(), $urandom(), $urandom());
  endtask

  // Fill the store, overflow it, search it whole, clear it, then query one new record
  task automatic test_full_store();
    logic [TS_W-1:0] tail;
    int unsigned     k;
    tail = $urandom_range(0, 1000);
    for (k = 0; k < DEPTH; k++) begin
      send_beat(OP_APPEND, tail, $urandom(), $urandom());
      tail = tail + $urandom_range(0, 7);
    end
    send_beat(OP_APPEND, tail,       $urandom(), $urandom());
    send_beat(OP_APPEND, TS_MAX,     $urandom(), $urandom());
    send_beat(OP_QUERY,  $urandom(), '0,         TS_MAX);
    send_beat(OP_QUERY,  $urandom(), TS_MAX,     TS_MAX);
    for (k = 0; k < 4; k++) begin
      send_beat(OP_QUERY, $urandom(), pick_bound(), pick_bound());
    end
    send_beat(OP_CLEAR,  $urandom(), $urandom(), $urandom());
    send_beat(OP_APPEND, tail,       $urandom(), $urandom());
    send_beat(OP_QUERY,  $urandom(), '0,         TS_MAX);
  endtask

  // Ascending runs with queries around held records, plus noise and clears
  task automatic test_random_traffic(int unsigned n_items);
    logic [TS_W-1:0] tail;
    logic [TS_W:0]   next_tail;
    logic [TS_W-1:0] qs;
    logic [TS_W-1:0] qe;
    int unsigned     k;
    int unsigned     sel;
    int unsigned     run_cap;
    tail    = $urandom() >> $urandom_range(0, 31);
    run_cap = $urandom_range(4, 40);
    for (k = 0; k < n_items; k++) begin
      if (k == n_items / 2) begin
        wait_results_drained();
      end
      sel = $urandom_range(0, 99);
      if (sel < 3 || shadow_count >= run_cap) begin
        send_beat(OP_CLEAR, $urandom(), $urandom(), $urandom());
        run_cap = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 40);
        case ($urandom_range(0, 3))
          0:       tail = '0;
          1:       tail = TS_MAX - $urandom_range(0, 300);
          default: tail = $urandom() >> $urandom_range(0, 31);
        endcase
      end else if (sel < 45) begin
        send_beat(OP_APPEND, tail, $urandom(), $urandom());
        case ($urandom_range(0, 3))
          0:       next_tail = {1'b0, tail};
          1:       next_tail = {1'b0, tail} + $urandom_range(1, 1000);
          default: next_tail = {1'b0, tail} + $urandom_range(1, 4);
        endcase
        tail = next_tail[TS_W] ? TS_MAX : next_tail[TS_W-1:0];
      end else if (sel < 50) begin
        // out-of-order record
        send_beat(OP_APPEND, $urandom(), $urandom(), $urandom());
      end else if (sel < 53) begin
        send_beat(OP_UNUSED, $urandom(), $urandom(), $urandom());
      end else begin
        qs = pick_bound();
        qe = pick_bound();
        if (qs > qe && $urandom_range(0, 4) != 0) begin
          send_beat(OP_QUERY, $urandom(), qe, qs);
        end else begin
          send_beat(OP_QUERY, $urandom(), qs, qe);
        end
      end
    end
  endtask

  // Check result beats, drive the sink stall pattern and guard the run length
  always @(posedge clk_i) begin
    res_t                   want;
    logic [OUT_TDATA_W-1:0] want_data;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timestamp_range_search_core verification failed");
      $finish;
    end else begin
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("unexpected result beat: status %0d tdata %h", m_axis_tuser,
                     m_axis_tdata);
          end
          mismatch_count++;
        end else begin
          want      = pending_results.pop_front();
          want_data = OUT_TDATA_W'({want.last_index, want.first_index});
          if (m_axis_tuser != want.status || m_axis_tdata != want_data) begin
            if (mismatch_count < REPORT_LIMIT) begin
              $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d (tdata %h)",
                       want.status, want.first_index, want.last_index, m_axis_tuser,
                       m_axis_tdata[IDX_W-1:0], m_axis_tdata[2*IDX_W-1:IDX_W], m_axis_tdata);
            end
            mismatch_count++;
          end
        end
      end
      // pick a new stall mode when the current stall phase runs out
      if (stall_phase == 0) begin
        stall_mode  = $urandom_range(0, 3);
        stall_phase = $urandom_range(16, 96);
      end
      stall_phase--;
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        2:       m_axis_tready <= ($urandom_range(0, 1) != 0);
        default: m_axis_tready <= ((stall_phase % 8) == 0);
      endcase
    end
  end

  // Reset once, run the tests in turn, then report
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_cases();
    wait_results_drained();
    test_full_store();
    test_random_traffic(RANDOM_ITEMS);
    wait_results_drained();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("timestamp_range_search_core verification clean");
    end else begin
      $display("timestamp_range_search_core verification failed");
    end
    $finish;
  end

endmodule
